// ===== rtl/iebm_pkg.sv =====
// shared types, codes and helpers for the i2c eeprom byte master
// no dependencies; imported by every module of the block
`default_nettype none

package iebm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_RECOVERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 3'd3;

  // register reset values
  localparam logic [15:0] RST_UNIT_TICKS  = 16'd100;
  localparam logic [7:0]  RST_ACK_TIMEOUT = 8'd250;
  localparam logic [23:0] RST_WR_RECOVERY = 24'd500000;
  localparam logic [6:0]  RST_DEV_ADDR    = 7'd80;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_W_START    = 5'd1,
    PH_W_DEV      = 5'd2,
    PH_W_DEV_ACK  = 5'd3,
    PH_W_ADDR     = 5'd4,
    PH_W_ADDR_ACK = 5'd5,
    PH_W_DATA     = 5'd6,
    PH_W_DATA_ACK = 5'd7,
    PH_W_STOP     = 5'd8,
    PH_W_RECOVER  = 5'd9,
    PH_R_START    = 5'd10,
    PH_R_DEV      = 5'd11,
    PH_R_DEV_ACK  = 5'd12,
    PH_R_ADDR     = 5'd13,
    PH_R_ADDR_ACK = 5'd14,
    PH_R_RESTART  = 5'd15,
    PH_R_DEVR     = 5'd16,
    PH_R_DEVR_ACK = 5'd17,
    PH_R_READ     = 5'd18,
    PH_R_NACK     = 5'd19,
    PH_R_STOP     = 5'd20,
    PH_ABORT      = 5'd21
  } phase_e;

  typedef enum logic [2:0] {
    K_IDLE    = 3'd0,
    K_START   = 3'd1,
    K_SEND    = 3'd2,
    K_ACK     = 3'd3,
    K_READ    = 3'd4,
    K_NACK    = 3'd5,
    K_STOP    = 3'd6,
    K_RECOVER = 3'd7
  } kind_e;

  // one input word after classification
  typedef struct packed {
    req_e       req;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda;
  } item_t;

  // one result word
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       ack_error;
  } res_t;

  function automatic kind_e kind_of(phase_e p);
    kind_e k;
    unique case (p) inside
      PH_W_START, PH_R_START, PH_R_RESTART:                    k = K_START;
      PH_W_DEV, PH_W_ADDR, PH_W_DATA,
      PH_R_DEV, PH_R_ADDR, PH_R_DEVR:                          k = K_SEND;
      PH_W_DEV_ACK, PH_W_ADDR_ACK, PH_W_DATA_ACK,
      PH_R_DEV_ACK, PH_R_ADDR_ACK, PH_R_DEVR_ACK:              k = K_ACK;
      PH_R_READ:                                               k = K_READ;
      PH_R_NACK:                                               k = K_NACK;
      PH_W_STOP, PH_R_STOP, PH_ABORT:                          k = K_STOP;
      PH_W_RECOVER:                                            k = K_RECOVER;
      default:                                                 k = K_IDLE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2c_eeprom_byte_master.sv =====
// i2c eeprom byte master: one word in gives one result word out.
// a word waits in the front queue; its result is registered in the result queue.
// throughput: one word per cycle while a word waits and the result queue has room.
// the front and result queues are two deep each, so either side may stall alone.
// reset: asynchronous active low; queues empty, master idle, registers at defaults.
// top level; instantiates iebm_front, iebm_seq, iebm_outq, depends on iebm_pkg
`default_nettype none

module i2c_eeprom_byte_master import iebm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [7:0]            mem_addr_i,
  input  wire logic [7:0]            write_data_i,
  input  wire logic                  sda_in_i,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic                       scl_out_o,
  output logic                       sda_out_o,
  output logic                       sda_drive_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic [7:0]                 read_byte_o,
  output logic                       ack_error_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic  item_valid, item_take;
  item_t item;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  iebm_front u_front (
    .clk_i,
    .rst_ni,
    .push_i,
    .full_o,
    .req_type_i,
    .mem_addr_i,
    .write_data_i,
    .sda_in_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  iebm_seq u_seq (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  iebm_outq u_outq (
    .clk_i,
    .rst_ni,
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop_i,
    .empty_o,
    .res_o      (res_out)
  );

  assign scl_out_o   = res_out.scl;
  assign sda_out_o   = res_out.sda;
  assign sda_drive_o = res_out.drive;
  assign busy_res_o  = res_out.busy;
  assign done_res_o  = res_out.done;
  assign read_byte_o = res_out.read_byte;
  assign ack_error_o = res_out.ack_error;

endmodule

`default_nettype wire

// ===== rtl/iebm_front.sv =====
// front end: classifies incoming words and holds them in a two-entry queue
// depends on iebm_pkg
`default_nettype none

module iebm_front import iebm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] mem_addr_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       sda_in_i,
  output logic            item_valid_o,
  output item_t           item_o,
  input  wire logic       item_take_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  item_t      item_in;

  // unknown request code behaves as a plain tick
  always_comb begin
    item_in.req        = (req_type_i == REQ_BAD) ? REQ_TICK : req_e'(req_type_i);
    item_in.mem_addr   = mem_addr_i;
    item_in.write_data = write_data_i;
    item_in.sda        = sda_in_i;
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iebm_seq.sv =====
// back end: bus sequencer stepping one word per cycle when a word waits and results have room, plus config registers
// depends on iebm_pkg
`default_nettype none

module iebm_seq import iebm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  item_valid_i,
  input  wire item_t                 item_i,
  output logic                       item_take_o,
  input  wire logic                  res_full_i,
  output logic                       res_push_o,
  output res_t                       res_o
);

  // configuration
  logic [15:0] unit_ticks_q;
  logic [7:0]  ack_timeout_q;
  logic [23:0] wr_recovery_q;
  logic [6:0]  dev_addr_q;

  // sequencer state
  phase_e      phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic [23:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  last_rd_q, last_rd_d;
  logic        err_q, err_d;
  logic        done;

  logic        step;
  kind_e       kind_q;
  logic [15:0] ut;
  logic [17:0] limit;
  logic [24:0] tick_inc;
  logic        hit;
  logic [3:0]  bit_inc;

  assign cfg_ready_o = 1'b1;
  assign step        = item_valid_i && !res_full_i;
  assign item_take_o = step;
  assign res_push_o  = step;

  assign kind_q   = kind_of(phase_q);
  assign ut       = (unit_ticks_q == 16'd0) ? 16'd1 : unit_ticks_q;
  // start and stop pieces last four units, bit pieces one
  assign limit    = (kind_q == K_START || kind_q == K_STOP) ? {ut, 2'b00} : {2'b00, ut};
  assign tick_inc = {1'b0, tick_q} + 25'd1;
  assign hit      = tick_inc >= {7'd0, limit};
  assign bit_inc  = bit_q + 4'd1;

  // next state
  always_comb begin
    logic   adv;
    logic   ent;
    phase_e ent_ph;
    adv       = 1'b0;
    ent       = 1'b0;
    ent_ph    = PH_IDLE;
    phase_d   = phase_q;
    sub_d     = sub_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    addr_d    = addr_q;
    data_d    = data_q;
    last_rd_d = last_rd_q;
    err_d     = err_q;
    done      = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.req == REQ_WRITE || item_i.req == REQ_READ) begin
        addr_d = item_i.mem_addr;
        data_d = item_i.write_data;
        err_d  = 1'b0;
        ent    = 1'b1;
        ent_ph = (item_i.req == REQ_WRITE) ? PH_W_START : PH_R_START;
      end
    end else begin
      unique case (kind_q)
        K_START, K_NACK: begin
          if (hit) begin
            tick_d = 24'd0;
            if (sub_q == 2'd0) sub_d = 2'd1;
            else adv = 1'b1;
          end else begin
            tick_d = tick_inc[23:0];
          end
        end
        K_SEND: begin
          if (hit) begin
            tick_d = 24'd0;
            if (sub_q < 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_inc;
              sub_d   = 2'd0;
              if (bit_inc >= BITS_PER_BYTE) adv = 1'b1;
            end
          end else begin
            tick_d = tick_inc[23:0];
          end
        end
        K_ACK: begin
          if (sub_q < 2'd2) begin
            if (hit) begin
              tick_d = 24'd0;
              sub_d  = sub_q + 2'd1;
            end else begin
              tick_d = tick_inc[23:0];
            end
          end else if (!item_i.sda) begin
            adv = 1'b1;
          end else if (poll_q >= ack_timeout_q) begin
            ent    = 1'b1;
            ent_ph = PH_ABORT;
          end else begin
            poll_d = poll_q + 8'd1;
          end
        end
        K_READ: begin
          if (hit) begin
            tick_d = 24'd0;
            if (sub_q == 2'd0) begin
              sub_d = 2'd1;
            end else begin
              shift_d = {shift_q[6:0], item_i.sda};
              bit_d   = bit_inc;
              sub_d   = 2'd0;
              if (bit_inc >= BITS_PER_BYTE) adv = 1'b1;
            end
          end else begin
            tick_d = tick_inc[23:0];
          end
        end
        K_STOP: begin
          if (hit) begin
            tick_d = 24'd0;
            if (sub_q < 2'd2) sub_d = sub_q + 2'd1;
            else adv = 1'b1;
          end else begin
            tick_d = tick_inc[23:0];
          end
        end
        K_RECOVER: begin
          tick_d = tick_inc[23:0];
          if (tick_inc[23:0] >= wr_recovery_q) adv = 1'b1;
        end
        default: begin
          ent    = 1'b1;
          ent_ph = PH_IDLE;
        end
      endcase
    end

    if (adv) begin
      ent = 1'b1;
      unique case (phase_q)
        PH_W_STOP: begin
          if (wr_recovery_q == 24'd0) begin
            ent_ph = PH_IDLE;
            done   = 1'b1;
          end else begin
            ent_ph = PH_W_RECOVER;
          end
        end
        PH_W_RECOVER: begin
          ent_ph = PH_IDLE;
          done   = 1'b1;
        end
        PH_R_STOP: begin
          last_rd_d = shift_q;
          ent_ph    = PH_IDLE;
          done      = 1'b1;
        end
        PH_ABORT: begin
          err_d  = 1'b1;
          ent_ph = PH_IDLE;
          done   = 1'b1;
        end
        default: ent_ph = phase_e'(phase_q + 5'd1);
      endcase
    end

    if (ent) begin
      phase_d = ent_ph;
      sub_d   = 2'd0;
      tick_d  = 24'd0;
      bit_d   = 4'd0;
      poll_d  = 8'd0;
      unique case (ent_ph) inside
        PH_W_DEV, PH_R_DEV:   shift_d = {dev_addr_q, 1'b0};
        PH_R_DEVR:            shift_d = {dev_addr_q, 1'b1};
        PH_W_ADDR, PH_R_ADDR: shift_d = addr_d;
        PH_W_DATA:            shift_d = data_d;
        PH_R_READ:            shift_d = 8'd0;
        default:              ;
      endcase
    end
  end

  // bus levels shown after the step
  always_comb begin
    kind_e kd;
    kd           = kind_of(phase_d);
    res_o.scl    = 1'b1;
    res_o.sda    = 1'b1;
    res_o.drive  = 1'b1;
    unique case (kd)
      K_START: res_o.sda = (sub_d == 2'd0);
      K_SEND: begin
        res_o.scl = (sub_d == 2'd1);
        res_o.sda = shift_d[7];
      end
      K_ACK: begin
        res_o.scl   = (sub_d >= 2'd1);
        res_o.drive = 1'b0;
      end
      K_READ: begin
        res_o.scl   = (sub_d == 2'd1);
        res_o.drive = 1'b0;
      end
      K_NACK: res_o.scl = (sub_d == 2'd1);
      K_STOP: begin
        res_o.scl = (sub_d >= 2'd1);
        res_o.sda = (sub_d == 2'd2);
      end
      default: ;
    endcase
    res_o.busy      = (phase_d != PH_IDLE);
    res_o.done      = done;
    res_o.read_byte = last_rd_d;
    res_o.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= RST_UNIT_TICKS;
      ack_timeout_q <= RST_ACK_TIMEOUT;
      wr_recovery_q <= RST_WR_RECOVERY;
      dev_addr_q    <= RST_DEV_ADDR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data_i[15:0];
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[7:0];
        CFG_WR_RECOVERY: wr_recovery_q <= cfg_data_i;
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[6:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sub_q     <= 2'd0;
      tick_q    <= 24'd0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      poll_q    <= 8'd0;
      addr_q    <= 8'd0;
      data_q    <= 8'd0;
      last_rd_q <= 8'd0;
      err_q     <= 1'b0;
    end else if (step) begin
      phase_q   <= phase_d;
      sub_q     <= sub_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      poll_q    <= poll_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      last_rd_q <= last_rd_d;
      err_q     <= err_d;
    end
  end

  // finishing word always leaves the master idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_o.done |=> phase_q == PH_IDLE)
    else $error("done without return to idle");

  // a byte never counts past eight bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q < BITS_PER_BYTE)
    else $error("bit counter overran");

  // sub-step stays within the three pieces of a bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("sub-step out of range");

  // sda is released only while waiting on ack or clocking in read bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !res_o.drive |-> (kind_of(phase_d) == K_ACK || kind_of(phase_d) == K_READ))
    else $error("sda released outside ack or read");

endmodule

`default_nettype wire

// ===== rtl/iebm_outq.sv =====
// result queue: two-entry buffer between the sequencer and the consumer
// depends on iebm_pkg
`default_nettype none

module iebm_outq import iebm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_push_i,
  input  wire res_t res_i,
  output logic      res_full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign res_o      = mem_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire
